@@ hw/rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the SQL LIKE wildcard matcher
// Pattern size default, wildcard codes, register indexes and the text item
// record used between the matcher's modules.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Built pattern size and config register geometry
  localparam int PATTERN_MAX_DEF = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_REG_W       = 6;
  localparam int BYTES_PER_REG   = 8;

  // Register indexes (pattern words use indexes 0 to 3)
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;

  // Wildcard codes
  localparam logic [7:0] PCT_CHAR = 8'h25;  // '%'
  localparam logic [7:0] ANY_CHAR = 8'h5F;  // '_'

  // One text item as held in the input stage
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_char;
    logic       last_char;
    logic       empty_text;
  } text_item_t;

endpackage

@@ hw/rtl/swm_ifs.sv @@
// ----------------------------------------------------------------------------
// swm_ifs: channel interfaces of the SQL LIKE wildcard matcher
// Text input channel, match result channel and configuration write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface swm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_char;
  logic       last_char;
  logic       empty_text;

  modport source (output valid, text_byte, first_char, last_char, empty_text,
                  input ready);
  modport sink   (input valid, text_byte, first_char, last_char, empty_text,
                  output ready);
endinterface

interface swm_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ hw/rtl/swm_row_update.sv @@
// ----------------------------------------------------------------------------
// swm_row_update: one step of the LIKE match row
// Applies percent closure to the stored row, advances it by one text byte
// and gives the match bit at the pattern length.
// ----------------------------------------------------------------------------
module swm_row_update #(
  parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF,
  localparam int ROW_W = PATTERN_MAX + 1,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] pattern,
  input  logic [LEN_W-1:0]            pat_len,
  input  logic [ROW_W-1:0]            row_in,
  input  swm_pkg::text_item_t         item,
  output logic [ROW_W-1:0]            row_next,
  output logic                        matched
);
  import swm_pkg::*;

  logic [PATTERN_MAX-1:0] active;
  logic [PATTERN_MAX-1:0] is_pct;
  logic [PATTERN_MAX-1:0] is_any;
  logic [PATTERN_MAX-1:0] is_hit;
  logic [ROW_W-1:0]       base;
  logic [ROW_W-1:0]       prev;
  logic [ROW_W-1:0]       next;

  // Per-byte class of the pattern, limited to the active length
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      active[j] = LEN_W'(j) < pat_len;
      is_pct[j] = active[j] && (pattern[j] == PCT_CHAR);
      is_any[j] = active[j] && (pattern[j] == ANY_CHAR);
      is_hit[j] = active[j] && (pattern[j] == item.text_byte);
    end
  end

  // Start row: fresh on a new or empty text
  assign base = (item.empty_text || item.first_char) ? ROW_W'(1) : row_in;

  // Percent closure of the start row
  always_comb begin
    prev = base;
    for (int j = 1; j < ROW_W; j++) begin
      prev[j] = prev[j] | (is_pct[j-1] & prev[j-1]);
    end
  end

  // Advance by one byte, then ripple through percent runs
  always_comb begin
    next = '0;
    for (int j = 1; j < ROW_W; j++) begin
      if (is_pct[j-1]) begin
        next[j] = prev[j] | next[j-1];
      end else begin
        next[j] = (is_any[j-1] | is_hit[j-1]) & prev[j-1];
      end
    end
  end

  // Match bit and row to keep
  assign matched  = item.empty_text ? prev[pat_len] : next[pat_len];
  assign row_next = (item.empty_text || item.last_char) ? ROW_W'(1) : next;

endmodule

@@ hw/rtl/sql_like_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher: streamed SQL LIKE pattern match
// Matches a text, one byte per item, against a configured LIKE pattern
// ('%' any run, '_' one byte, other bytes exact) and gives one match bit
// at the end of each text.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  text_in     in   valid/ready    text_byte, first_char, last_char, empty_text
//  result_out  out  valid/ready    matched
//  cfg         in   valid/ready    reg_index, wr_data (always ready)
//
// One item per cycle sustained while no held result stalls a text end; an item
// goes through the input register, then the row update into the result register.
// The row update, closure ripple included, is combinational logic.
// Reset clears the config registers and both valid flags and restarts the row.
// A held result stalls only an item that would make another result;
// bytes inside a text keep flowing.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher #(
  parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  swm_text_if.sink     text_in,
  swm_result_if.source result_out,
  swm_cfg_if.sink      cfg
);
  import swm_pkg::*;

  localparam int ROW_W = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0] pattern;
  logic [LEN_REG_W-1:0]        length_reg;
  logic [LEN_W-1:0]            pat_len;
  logic [ROW_W-1:0]            match_row;
  logic [ROW_W-1:0]            row_next;
  logic                        row_matched;
  logic                        stage_valid;
  text_item_t                  stage_item;
  logic                        gives_result;
  logic                        out_free;
  logic                        advance;
  logic                        out_valid;
  logic                        out_matched;

  // Config writes, always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= '0;
      length_reg <= '0;
    end else if (cfg.valid) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if ((cfg.reg_index < REG_LENGTH) && (cfg.reg_index == CFG_IDX_W'(j >> 3))) begin
          pattern[j] <= cfg.wr_data[(j & (BYTES_PER_REG - 1)) * 8 +: 8];
        end
      end
      if (cfg.reg_index == REG_LENGTH) begin
        length_reg <= cfg.wr_data[LEN_REG_W-1:0];
      end
    end
  end

  // Length saturates at the built size
  assign pat_len = (length_reg > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : LEN_W'(length_reg);

  // Handshake control
  assign gives_result   = stage_item.last_char | stage_item.empty_text;
  assign out_free       = !out_valid || result_out.ready;
  assign advance        = stage_valid && (!gives_result || out_free);
  assign text_in.ready  = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_in.ready) begin
      stage_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      stage_item.text_byte  <= text_in.text_byte;
      stage_item.first_char <= text_in.first_char;
      stage_item.last_char  <= text_in.last_char;
      stage_item.empty_text <= text_in.empty_text;
    end
  end

  // Row update
  swm_row_update #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_row_update (
    .pattern  (pattern),
    .pat_len  (pat_len),
    .row_in   (match_row),
    .item     (stage_item),
    .row_next (row_next),
    .matched  (row_matched)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_row <= ROW_W'(1);
    end else if (advance) begin
      match_row <= row_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !result_out.ready) || (advance && gives_result);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && gives_result) begin
      out_matched <= row_matched;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.matched = out_matched;

  // Checks
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> (out_valid && !result_out.ready))
    else $error("input stage stalled with a free result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && gives_result) |=> out_valid)
    else $error("text end gave no result");

  a_row_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && gives_result) |=> (match_row == ROW_W'(1)))
    else $error("row not restarted after text end");

endmodule
